@@ hdl/mbt2r_pkg.sv @@
// Shared types and constants for the macroblock tile-to-raster address generator.
// No dependencies; imported by macroblock_tile_to_raster.
`timescale 1ns / 1ps

package mbt2r_pkg;

    // Tile geometry: luma tiles are 16x16 bytes, chroma tiles carry 16 interleaved bytes a row
    localparam int TILE_SIZE      = 16;
    localparam int TILE_LOG2      = 4;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int ROW_LIMIT      = 256;

    localparam int FRAME_DIM_W    = 13;
    localparam int LUMA_STRIDE_W  = 14;
    localparam int CHROMA_STRIDE_W = 13;
    localparam int CFG_DATA_W     = 14;
    localparam int CFG_INDEX_W    = 2;
    localparam int ADDR_W         = 25;
    localparam int LINE_W         = 12;   // tile_row * 16 + row_in_tile
    localparam int TROW_W         = 8;
    localparam int LIM_W          = 9;    // a count of up to 256 tile rows
    localparam int PROD_W         = LINE_W + LUMA_STRIDE_W;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_LUMA_STRIDE   = 2'd2,
        REG_CHROMA_STRIDE = 2'd3
    } cfg_reg_t;

    // Destination plane codes
    localparam logic [1:0] PLANE_LUMA = 2'd0;
    localparam logic [1:0] PLANE_U    = 2'd1;
    localparam logic [1:0] PLANE_V    = 2'd2;

    localparam logic [FRAME_DIM_W-1:0]     WIDTH_RST   = 13'd720;
    localparam logic [FRAME_DIM_W-1:0]     HEIGHT_RST  = 13'd480;
    localparam logic [LUMA_STRIDE_W-1:0]   LSTRIDE_RST = 14'd720;
    localparam logic [CHROMA_STRIDE_W-1:0] CSTRIDE_RST = 13'd360;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       frame_start;
    } pix_req_t;

    typedef struct packed {
        logic [1:0]        plane;
        logic [ADDR_W-1:0] dest_address;
        logic [7:0]        out_byte;
        logic              frame_last;
    } res_req_t;

endpackage

@@ hdl/macroblock_tile_to_raster.sv @@
// Macroblock tile-to-raster address generator: top level.
// Depends on mbt2r_pkg (types, plane codes, register indexes).
`timescale 1ns / 1ps

// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------
// pix      | pix_valid/pix_stall| pix_req_t: pixel_byte, frame_start
// res      | res_valid/res_stall| res_req_t: plane, dest_address, out_byte, frame_last
// cfg      | cfg_write          | cfg_index, cfg_data (no read-back)
//
// One request per cycle while res is not stalled; an accepted request is registered in
// stage 1, then in the result register, from which it is offered on res.
// Stage 1 steps the tile position counters and latches column/line; stage 2 does the
// one line * stride multiply and the add. Reset clears the counters and valid bits and
// loads the default frame setup (720x480). A stall on res backs up through both stages;
// pix_stall rises only when both stages hold requests and res is stalled.

module macroblock_tile_to_raster #(
    parameter int MAX_WIDTH = mbt2r_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pix_valid,
    output logic                                  pix_stall,
    input  mbt2r_pkg::pix_req_t                   pix,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output mbt2r_pkg::res_req_t                   res,
    input  logic                                  cfg_write,
    input  logic [mbt2r_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbt2r_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mbt2r_pkg::*;

    localparam int MAX_COLS = MAX_WIDTH / TILE_SIZE;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W    = COL_W + 1;              // holds MAX_COLS itself
    localparam int LCOL_W   = COL_W + TILE_LOG2;      // luma column width
    localparam int CW_W     = FRAME_DIM_W - TILE_LOG2; // frame_width / 16

    // ---------------- configuration registers ----------------
    logic [FRAME_DIM_W-1:0]     width_reg, height_reg;
    logic [LUMA_STRIDE_W-1:0]   lstride_reg;
    logic [CHROMA_STRIDE_W-1:0] cstride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            lstride_reg <= LSTRIDE_RST;
            cstride_reg <= CSTRIDE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:   width_reg   <= cfg_data[FRAME_DIM_W-1:0];
                REG_FRAME_HEIGHT:  height_reg  <= cfg_data[FRAME_DIM_W-1:0];
                REG_LUMA_STRIDE:   lstride_reg <= cfg_data;
                REG_CHROMA_STRIDE: cstride_reg <= cfg_data[CHROMA_STRIDE_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- tile counts, clamped ----------------
    logic [CW_W-1:0]  cols_raw;
    logic [CNT_W-1:0] cols;
    logic [CW_W-1:0]  rows_l_raw;
    logic [CW_W-2:0]  rows_c_raw;
    logic [LIM_W-1:0] rows_l, rows_c, rows;

    assign cols_raw   = width_reg[FRAME_DIM_W-1:TILE_LOG2];
    assign rows_l_raw = height_reg[FRAME_DIM_W-1:TILE_LOG2];
    assign rows_c_raw = height_reg[FRAME_DIM_W-1:TILE_LOG2+1];

    always_comb
    begin
        if (cols_raw == '0)
            cols = CNT_W'(1);
        else if (CNT_W'(cols_raw) > CNT_W'(MAX_COLS) || (CW_W > CNT_W &&
                 (cols_raw >> CNT_W) != '0))
            cols = CNT_W'(MAX_COLS);
        else
            cols = CNT_W'(cols_raw);

        if (rows_l_raw == '0)
            rows_l = LIM_W'(1);
        else if (rows_l_raw > CW_W'(ROW_LIMIT))
            rows_l = LIM_W'(ROW_LIMIT);
        else
            rows_l = LIM_W'(rows_l_raw);

        if (rows_c_raw == '0)
            rows_c = LIM_W'(1);
        else
            rows_c = LIM_W'(rows_c_raw);  // at most 255, under the limit
    end

    // ---------------- position counters ----------------
    logic                 chroma_reg, chroma_next;
    logic [3:0]           byte_reg, byte_next;
    logic [3:0]           row_reg, row_next;
    logic [COL_W-1:0]     tcol_reg, tcol_next;
    logic [TROW_W-1:0]    trow_reg, trow_next;

    // frame_start clears the position before this byte is placed
    logic                 e_chroma;
    logic [3:0]           e_byte, e_row;
    logic [COL_W-1:0]     e_tcol;
    logic [TROW_W-1:0]    e_trow;
    logic                 wrap_byte, wrap_row, wrap_col, wrap_trow, wrap_all;
    logic                 last_c;

    assign e_chroma = pix.frame_start ? 1'b0 : chroma_reg;
    assign e_byte   = pix.frame_start ? '0   : byte_reg;
    assign e_row    = pix.frame_start ? '0   : row_reg;
    assign e_tcol   = pix.frame_start ? '0   : tcol_reg;
    assign e_trow   = pix.frame_start ? '0   : trow_reg;

    assign rows      = e_chroma ? rows_c : rows_l;
    assign wrap_byte = (e_byte == 4'(TILE_SIZE - 1));
    assign wrap_row  = (e_row == 4'(TILE_SIZE - 1));
    // at-or-beyond test covers a limit lowered mid-frame
    assign wrap_col  = (CNT_W'(e_tcol) + CNT_W'(1)) >= cols;
    assign wrap_trow = (LIM_W'(e_trow) + LIM_W'(1)) >= rows;
    assign wrap_all  = wrap_byte & wrap_row & wrap_col & wrap_trow;
    assign last_c    = wrap_all & e_chroma;

    always_comb
    begin
        byte_next   = e_byte + 4'd1;
        row_next    = e_row;
        tcol_next   = e_tcol;
        trow_next   = e_trow;
        chroma_next = e_chroma;
        if (wrap_byte)
        begin
            row_next = e_row + 4'd1;
            if (wrap_row)
            begin
                tcol_next = wrap_col ? '0 : e_tcol + COL_W'(1);
                if (wrap_col)
                begin
                    trow_next = wrap_trow ? '0 : e_trow + TROW_W'(1);
                    if (wrap_trow)
                        chroma_next = ~e_chroma;
                end
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, res_valid_reg;
    logic res_open, s1_open, pix_take;

    assign res_open  = !res_valid_reg || !res_stall;
    assign s1_open   = !s1_valid_reg || res_open;
    assign pix_stall = !s1_open;
    assign pix_take  = pix_valid && s1_open;
    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chroma_reg    <= 1'b0;
            byte_reg      <= '0;
            row_reg       <= '0;
            tcol_reg      <= '0;
            trow_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_take)
            begin
                chroma_reg <= chroma_next;
                byte_reg   <= byte_next;
                row_reg    <= row_next;
                tcol_reg   <= tcol_next;
                trow_reg   <= trow_next;
            end
            if (s1_open)
                s1_valid_reg <= pix_valid;
            if (res_open)
                res_valid_reg <= s1_valid_reg;
        end
    end

    // ---------------- stage 1: column, line, plane ----------------
    logic [LCOL_W-1:0] col_c;
    logic [LINE_W-1:0] line_c;
    logic [1:0]        plane_c;

    always_comb
    begin
        line_c = {e_trow, e_row};
        if (e_chroma)
        begin
            // interleaved U/V: two bytes per chroma sample
            col_c   = LCOL_W'({e_tcol, 3'b000}) + LCOL_W'(e_byte[3:1]);
            plane_c = e_byte[0] ? PLANE_V : PLANE_U;
        end
        else
        begin
            col_c   = {e_tcol, e_byte};
            plane_c = PLANE_LUMA;
        end
    end

    logic [LCOL_W-1:0]        s1_col_reg;
    logic [LINE_W-1:0]        s1_line_reg;
    logic [LUMA_STRIDE_W-1:0] s1_stride_reg;
    logic [1:0]               s1_plane_reg;
    logic [7:0]               s1_byte_reg;
    logic                     s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            s1_col_reg    <= col_c;
            s1_line_reg   <= line_c;
            s1_stride_reg <= e_chroma ? LUMA_STRIDE_W'(cstride_reg) : lstride_reg;
            s1_plane_reg  <= plane_c;
            s1_byte_reg   <= pix.pixel_byte;
            s1_last_reg   <= last_c;
        end
    end

    // ---------------- stage 2: line * stride + column ----------------
    logic [PROD_W-1:0] prod_c;
    logic [PROD_W-1:0] sum_c;
    res_req_t          res_reg;

    assign prod_c = PROD_W'(s1_line_reg) * PROD_W'(s1_stride_reg);
    assign sum_c  = prod_c + PROD_W'(s1_col_reg);

    always_ff @(posedge clk)
    begin
        if (res_open && s1_valid_reg)
        begin
            res_reg.plane        <= s1_plane_reg;
            res_reg.dest_address <= sum_c[ADDR_W-1:0];
            res_reg.out_byte     <= s1_byte_reg;
            res_reg.frame_last   <= s1_last_reg;
        end
    end

    assign res = res_reg;

endmodule

@@ tb/mbt2r_placement_checker.sv @@
// Placement checker for macroblock_tile_to_raster: watches pix, res and cfg,
// predicts plane/address/last-byte per accepted request and compares in order.
// Depends on mbt2r_pkg for request types, plane codes and register indexes.
`timescale 1ns / 1ps

module mbt2r_placement_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    input  logic                              pix_stall,
    input  mbt2r_pkg::pix_req_t               pix,
    input  logic                              res_valid,
    input  logic                              res_stall,
    input  mbt2r_pkg::res_req_t               res,
    input  logic                              cfg_write,
    input  logic [mbt2r_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbt2r_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                mismatches,
    output int                                pending
);
    import mbt2r_pkg::*;

    // Shadow of the frame setup
    logic [FRAME_DIM_W-1:0]     width_q   = WIDTH_RST;
    logic [FRAME_DIM_W-1:0]     height_q  = HEIGHT_RST;
    logic [LUMA_STRIDE_W-1:0]   lstride_q = LSTRIDE_RST;
    logic [CHROMA_STRIDE_W-1:0] cstride_q = CSTRIDE_RST;

    // Tile position
    logic       in_chroma = 1'b0;
    logic [3:0] byte_pos  = '0;
    logic [3:0] tile_line = '0;
    logic [7:0] tile_col  = '0;
    logic [7:0] tile_row  = '0;

    res_req_t placements_due[$];

    function automatic int clamp_tiles(int n, int hi);
        if (n < 1)
            return 1;
        if (n > hi)
            return hi;
        return n;
    endfunction

    function automatic res_req_t place_byte(pix_req_t req);
        int       cols;
        int       rows;
        longint   col;
        longint   line;
        longint   addr;
        res_req_t r;
        cols = clamp_tiles(int'(width_q) / TILE_SIZE, MAX_WIDTH_DEF / TILE_SIZE);
        if (req.frame_start)
        begin
            in_chroma = 1'b0;
            byte_pos  = '0;
            tile_line = '0;
            tile_col  = '0;
            tile_row  = '0;
        end
        line = longint'(tile_row) * TILE_SIZE + longint'(tile_line);
        if (in_chroma)
        begin
            // chroma tiles: 8 samples wide, U/V interleaved byte by byte
            rows    = clamp_tiles(int'(height_q) / (2 * TILE_SIZE), ROW_LIMIT);
            col     = longint'(tile_col) * (TILE_SIZE / 2) + longint'(byte_pos >> 1);
            addr    = col + line * longint'(cstride_q);
            r.plane = byte_pos[0] ? PLANE_V : PLANE_U;
        end
        else
        begin
            rows    = clamp_tiles(int'(height_q) / TILE_SIZE, ROW_LIMIT);
            col     = longint'(tile_col) * TILE_SIZE + longint'(byte_pos);
            addr    = col + line * longint'(lstride_q);
            r.plane = PLANE_LUMA;
        end
        r.dest_address = addr[ADDR_W-1:0];
        r.out_byte     = req.pixel_byte;
        r.frame_last   = 1'b0;

        // counters beyond a shrunken limit wrap on the next carry
        if (byte_pos != 4'd15)
            byte_pos++;
        else
        begin
            byte_pos = '0;
            if (tile_line != 4'd15)
                tile_line++;
            else
            begin
                tile_line = '0;
                if (int'(tile_col) + 1 < cols)
                    tile_col++;
                else
                begin
                    tile_col = '0;
                    if (int'(tile_row) + 1 < rows)
                        tile_row++;
                    else
                    begin
                        tile_row     = '0;
                        r.frame_last = in_chroma;
                        in_chroma    = ~in_chroma;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_req_t due;
        if (!rst_n)
        begin
            width_q   = WIDTH_RST;
            height_q  = HEIGHT_RST;
            lstride_q = LSTRIDE_RST;
            cstride_q = CSTRIDE_RST;
            in_chroma = 1'b0;
            byte_pos  = '0;
            tile_line = '0;
            tile_col  = '0;
            tile_row  = '0;
            placements_due.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:   width_q   = cfg_data[FRAME_DIM_W-1:0];
                    REG_FRAME_HEIGHT:  height_q  = cfg_data[FRAME_DIM_W-1:0];
                    REG_LUMA_STRIDE:   lstride_q = cfg_data[LUMA_STRIDE_W-1:0];
                    REG_CHROMA_STRIDE: cstride_q = cfg_data[CHROMA_STRIDE_W-1:0];
                    default: ;
                endcase
            end
            if (pix_valid && !pix_stall)
                placements_due.push_back(place_byte(pix));
            if (res_valid && !res_stall)
            begin
                if (placements_due.size() == 0)
                begin
                    $error("res: request with nothing outstanding (addr %0d)",
                           res.dest_address);
                    mismatches++;
                end
                else
                begin
                    due = placements_due.pop_front();
                    if (res.plane !== due.plane)
                    begin
                        $error("plane: expected %0d, got %0d", due.plane, res.plane);
                        mismatches++;
                    end
                    if (res.dest_address !== due.dest_address)
                    begin
                        $error("dest_address: expected %0d, got %0d",
                               due.dest_address, res.dest_address);
                        mismatches++;
                    end
                    if (res.out_byte !== due.out_byte)
                    begin
                        $error("out_byte: expected %0h, got %0h", due.out_byte, res.out_byte);
                        mismatches++;
                    end
                    if (res.frame_last !== due.frame_last)
                    begin
                        $error("frame_last: expected %0b, got %0b",
                               due.frame_last, res.frame_last);
                        mismatches++;
                    end
                end
            end
            pending = placements_due.size();
        end
    end

endmodule

@@ tb/macroblock_tile_to_raster_tb.sv @@
// Testbench top for macroblock_tile_to_raster: drives pixel requests and frame
// setups, stalls the result side at random, and reports the verdict.
// Depends on mbt2r_pkg, macroblock_tile_to_raster and mbt2r_placement_checker.
`timescale 1ns / 1ps

module macroblock_tile_to_raster_tb;
    import mbt2r_pkg::*;

    // Hard stop; the slowest legal run needs only a small fraction of this
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_PIXELS = 90;
    localparam int CORNER_COUNT = 20;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    pix_req_t               pix       = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    res_req_t               res;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;    // chance per cycle that the pixel source holds back
    int stall_pct     = 0;    // chance per cycle that the result sink stalls

    // Byte values for the opening directed run: both rails and alternating bits
    logic [7:0] corner_bytes [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};

    macroblock_tile_to_raster dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mbt2r_placement_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result-side backpressure: redrawn every cycle so stalls land on every
    // pipeline phase; stall_pct = 0 gives stretches of full throughput.
    always @(negedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: also catches results that never show up
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[macroblock_tile_to_raster] ERROR");
            $finish;
        end
    end

    // One pixel request. Entered and left at a falling edge. valid stays high
    // on return so back-to-back requests never drop it in between; the caller
    // lowers it through wait_drained once a batch is done.
    task automatic send_pixel(input logic [7:0] value, input logic start);
        pix_req_t req;
        req.pixel_byte = value;
        req.frame_start = start;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= req;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait for every predicted placement to come back.
    // Every request yields a result, so an empty queue means the pipe is
    // empty.
    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // Loads all four registers back to back, then drops the write strobe
    task automatic program_frame(input logic [CFG_DATA_W-1:0] width,
                                 input logic [CFG_DATA_W-1:0] height,
                                 input logic [CFG_DATA_W-1:0] lstride,
                                 input logic [CFG_DATA_W-1:0] cstride);
        write_reg(REG_FRAME_WIDTH, width);
        write_reg(REG_FRAME_HEIGHT, height);
        write_reg(REG_LUMA_STRIDE, lstride);
        write_reg(REG_CHROMA_STRIDE, cstride);
        cfg_write <= 1'b0;
    endtask

    // Under 32x32 the tile counts clamp to one, so a full frame (one luma and
    // one chroma tile) is only 512 bytes and the frame-end wrap gets exercised.
    task automatic program_tiny_frame();
        program_frame(CFG_DATA_W'($urandom_range(31)), CFG_DATA_W'($urandom_range(31)),
                      CFG_DATA_W'($urandom_range(16383)), CFG_DATA_W'($urandom_range(16383)));
    endtask

    initial
    begin
        int kind;

        // Reset once, then wait for a falling edge before the first request
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender mostly busy, receiver mostly stalled
        send_idle_pct = 11;
        stall_pct     = 75;

        // Directed run on the reset setup (720x480): extreme byte values,
        // a frame start on the first byte and another in mid-tile to check
        // the position clear.
        for (int i = 0; i < CORNER_COUNT; i++)
            send_pixel(corner_bytes[i % 8], (i == 0) || (i == 12));

        // Random phases. The position counters run on across phases, so the
        // setups are ordered to make the first tile boundary switch to chroma
        // and the second one end the frame; in between the setups change
        // under a partly done frame, including shrinking past the counters.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            if (phase == 3)
            begin
                send_idle_pct = 75;
                stall_pct     = 11;
            end
            else if (phase == 6)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end

            case (phase)
                0: program_frame(0, 0, 16383, 8191);          // all-zero sizes, widest strides
                1: program_frame(8191, 8191, 0, 0);           // clamped tile counts, zero strides
                3: program_frame(32, 32, 32, 16);             // smallest legal frame
                4: program_frame(4096, 4096, 8192, 4096);     // largest legal frame
                6:
                begin
                    kind = $urandom_range(3);
                    if (kind == 0)
                        program_tiny_frame();
                    else if (kind == 1)
                        program_frame(CFG_DATA_W'($urandom_range(1, 128) * 32),
                                      CFG_DATA_W'($urandom_range(1, 128) * 32),
                                      CFG_DATA_W'($urandom_range(32, 8192)),
                                      CFG_DATA_W'($urandom_range(16, 4096)));
                    else
                        program_frame(CFG_DATA_W'($urandom_range(16383)),
                                      CFG_DATA_W'($urandom_range(16383)),
                                      CFG_DATA_W'($urandom_range(16383)),
                                      CFG_DATA_W'($urandom_range(16383)));
                end
                default: program_tiny_frame();
            endcase
            @(negedge clk);

            // Rare frame starts restart the frame as noise on top of the stream
            for (int k = 0; k < PHASE_PIXELS; k++)
                send_pixel(8'($urandom_range(255)), $urandom_range(1023) == 0);
        end

        wait_drained();
        if (mismatches == 0)
            $display("[macroblock_tile_to_raster] OK");
        else
            $display("[macroblock_tile_to_raster] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mbt2r_pkg.sv
hdl/macroblock_tile_to_raster.sv
tb/mbt2r_placement_checker.sv
tb/macroblock_tile_to_raster_tb.sv
